/* rtl/ffcp_pkg.sv */
// Shared types and constants for the fixed-frame checksum parser.
package ffcp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PAYLOAD_LEN = 9;
    localparam int unsigned SHIFT_W = PAYLOAD_LEN * BYTE_W;
    localparam int unsigned FIRST_W = (PAYLOAD_LEN - 1) * BYTE_W;
    localparam int unsigned CFG_ADDR_W = 8;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] SUM_POS = COUNT_W'(PAYLOAD_LEN);
    localparam logic [COUNT_W-1:0] TAIL_POS = COUNT_W'(PAYLOAD_LEN + 1);

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hA5;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h5A;

    localparam logic [CFG_ADDR_W-1:0] REG_HEADER = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TAIL = 8'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SUM = 2'd2;

    typedef enum logic {
        FS_HUNT,
        FS_FRAME
    } front_state_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_SUM,
        KIND_TAIL
    } byte_kind_t;

    typedef struct packed {
        byte_kind_t        kind;
        logic [BYTE_W-1:0] data;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

/* rtl/ffcp_front.sv */
// Front end: hunts for the header and tags each frame byte by its position.
module ffcp_front
    import ffcp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_rx_byte,
    input  logic [BYTE_W-1:0]   header_byte,
    input  queue_status_t       q_status,
    output logic                push,
    output queue_entry_t        push_entry
);

    front_state_t         state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 accept;

    // While hunting, bytes are dropped or start a frame, so no queue space is needed.
    assign s_ready = (state_reg == FS_HUNT) || !q_status.full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_HUNT;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        push            = 1'b0;
        push_entry.kind = KIND_PAYLOAD;
        push_entry.data = s_rx_byte;
        if (accept) begin
            unique case (state_reg)
                FS_HUNT: begin
                    if (s_rx_byte == header_byte) begin
                        state_next = FS_FRAME;
                        count_next = '0;
                    end
                end
                FS_FRAME: begin
                    push = 1'b1;
                    if (count_reg < SUM_POS) begin
                        push_entry.kind = KIND_PAYLOAD;
                        count_next      = count_reg + 1'b1;
                    end else if (count_reg == SUM_POS) begin
                        push_entry.kind = KIND_SUM;
                        count_next      = TAIL_POS;
                    end else begin
                        // any later position closes the frame
                        push_entry.kind = KIND_TAIL;
                        state_next      = FS_HUNT;
                        count_next      = '0;
                    end
                end
                default: begin
                    state_next = FS_HUNT;
                end
            endcase
        end
    end

endmodule

/* rtl/ffcp_queue.sv */
// Short queue of tagged bytes between the front and back ends.
module ffcp_queue
    import ffcp_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  queue_entry_t    push_entry,
    input  logic            pop,
    output queue_entry_t    head_entry,
    output queue_status_t   q_status
);

    queue_entry_t              entry_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]    count_reg;
    logic                      do_push;
    logic                      do_pop;

    assign q_status.full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_status.not_empty = (count_reg != '0);
    assign head_entry         = entry_mem[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && q_status.not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/ffcp_back.sv */
// Back end: collects payload, sums it, checks sum and tail, holds the result.
module ffcp_back
    import ffcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  queue_status_t         q_status,
    input  queue_entry_t          head_entry,
    output logic                  pop,
    input  logic [BYTE_W-1:0]     tail_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_frame_status,
    output logic [FIRST_W-1:0]    m_payload_first_eight,
    output logic [BYTE_W-1:0]     m_payload_ninth
);

    logic                   m_valid_reg;
    logic [BYTE_W-1:0]      sum_reg;
    logic [BYTE_W-1:0]      rx_sum_reg;
    logic [SHIFT_W-1:0]     shift_reg;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [FIRST_W-1:0]     first_reg;
    logic [BYTE_W-1:0]      ninth_reg;
    logic                   is_tail;

    assign is_tail = (head_entry.kind == KIND_TAIL);
    // A tail needs a free output slot; other bytes always drain.
    assign pop = q_status.not_empty && (!is_tail || !m_valid_reg || m_ready);

    always_comb begin
        priority if (head_entry.data != tail_byte) begin
            status_next = STATUS_BAD_TAIL;
        end else if (rx_sum_reg != sum_reg) begin
            status_next = STATUS_BAD_SUM;
        end else begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sum_reg     <= '0;
        end else begin
            if (pop && is_tail) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop) begin
                unique case (head_entry.kind)
                    KIND_PAYLOAD: sum_reg <= sum_reg + head_entry.data;
                    KIND_TAIL:    sum_reg <= '0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            unique case (head_entry.kind)
                KIND_PAYLOAD: shift_reg <= {shift_reg[SHIFT_W-BYTE_W-1:0], head_entry.data};
                KIND_SUM:     rx_sum_reg <= head_entry.data;
                KIND_TAIL: begin
                    status_reg <= status_next;
                    first_reg  <= shift_reg[SHIFT_W-1:BYTE_W];
                    ninth_reg  <= shift_reg[BYTE_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_frame_status        = status_reg;
    assign m_payload_first_eight = first_reg;
    assign m_payload_ninth       = ninth_reg;

endmodule

/* rtl/fixed_frame_checksum_parser.sv */
// Top level of the fixed-frame checksum parser.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_rx_byte
//  m_       out        m_valid / m_ready    m_frame_status, m_payload_first_eight,
//                                           m_payload_ninth
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while s_ready is high. A frame byte is tagged by the front end and reaches
// the back end through a two-entry queue; m_valid is registered when the back end pops the tail.
// Synchronous active-low reset restores the header and tail values and clears all control
// state. A stalled result blocks only the tail of the next frame; payload keeps draining,
// and input stalls once the queue fills. Configuration writes are taken every cycle.
module fixed_frame_checksum_parser
    import ffcp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [BYTE_W-1:0]       s_rx_byte,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_W-1:0]     m_frame_status,
    output logic [FIRST_W-1:0]      m_payload_first_eight,
    output logic [BYTE_W-1:0]       m_payload_ninth,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_ADDR_W-1:0]   cfg_index,
    input  logic [BYTE_W-1:0]       cfg_data
);

    logic [BYTE_W-1:0]  header_byte_reg;
    logic [BYTE_W-1:0]  tail_byte_reg;
    logic               push;
    logic               pop;
    queue_entry_t       push_entry;
    queue_entry_t       head_entry;
    queue_status_t      q_status;

    assign cfg_ready = 1'b1;

    // Drop writes to unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_byte_reg <= HEADER_RESET;
            tail_byte_reg   <= TAIL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_HEADER) begin
                header_byte_reg <= cfg_data;
            end else if (cfg_index == REG_TAIL) begin
                tail_byte_reg <= cfg_data;
            end
        end
    end

    ffcp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .header_byte (header_byte_reg),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    ffcp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    ffcp_back u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .q_status              (q_status),
        .head_entry            (head_entry),
        .pop                   (pop),
        .tail_byte             (tail_byte_reg),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_frame_status        (m_frame_status),
        .m_payload_first_eight (m_payload_first_eight),
        .m_payload_ninth       (m_payload_ninth)
    );

endmodule

/* rtl/ffcp_checker.sv */
// Port-level checks for the fixed-frame checksum parser, bound to the top level.
module ffcp_checker
    import ffcp_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [STATUS_W-1:0]    m_frame_status,
    input logic [FIRST_W-1:0]     m_payload_first_eight,
    input logic                   cfg_ready
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_first_eight))
        else $error("stalled result dropped or changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_status == STATUS_OK) || (m_frame_status == STATUS_BAD_TAIL)
                    || (m_frame_status == STATUS_BAD_SUM))
        else $error("undefined frame status");

    a_cfg_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind fixed_frame_checksum_parser ffcp_checker u_ffcp_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_frame_status        (m_frame_status),
    .m_payload_first_eight (m_payload_first_eight),
    .cfg_ready             (cfg_ready)
);

/* bench/frame_result_checker.sv */
// Result checker for the fixed-frame checksum parser: tracks frames, predicts and compares.
`timescale 1ns / 1ps

module frame_result_checker
    import ffcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_rx_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [STATUS_W-1:0]   m_frame_status,
    input  logic [FIRST_W-1:0]    m_payload_first_eight,
    input  logic [BYTE_W-1:0]     m_payload_ninth,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data,
    output int                    mismatches,
    output int                    frames_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIRST_W-1:0]  first_eight;
        logic [BYTE_W-1:0]   ninth;
    } frame_report_t;

    frame_report_t awaited_frames[$];

    logic [BYTE_W-1:0]  header_value;
    logic [BYTE_W-1:0]  tail_value;
    front_state_t       parse_state;
    logic [COUNT_W-1:0] bytes_in;
    logic [BYTE_W-1:0]  sum_acc;
    logic [BYTE_W-1:0]  sum_rx;
    logic [BYTE_W-1:0]  body [PAYLOAD_LEN];
    int                 reports_shown;

    initial begin
        mismatches = 0;
        reports_shown = 0;
        frames_pending = 0;
    end

    task automatic note_error(input string what);
        mismatches++;
        if (reports_shown < 10) begin
            reports_shown++;
            $display("%0t: checker: %s", $time, what);
        end
    endtask

    task automatic take_rx_byte(input logic [BYTE_W-1:0] b);
        frame_report_t r;
        int i;
        if (parse_state == FS_HUNT) begin
            if (b == header_value) begin
                parse_state = FS_FRAME;
                bytes_in = '0;
                sum_acc = '0;
            end
        end else if (bytes_in < SUM_POS) begin
            body[bytes_in] = b;
            sum_acc = sum_acc + b;
            bytes_in = bytes_in + 1'b1;
        end else if (bytes_in == SUM_POS) begin
            sum_rx = b;
            bytes_in = TAIL_POS;
        end else begin
            // tail byte closes the frame; tail is judged before the sum
            if (b != tail_value)
                r.status = STATUS_BAD_TAIL;
            else if (sum_rx != sum_acc)
                r.status = STATUS_BAD_SUM;
            else
                r.status = STATUS_OK;
            for (i = 0; i < PAYLOAD_LEN - 1; i++)
                r.first_eight[FIRST_W-1-BYTE_W*i -: BYTE_W] = body[i];
            r.ninth = body[PAYLOAD_LEN-1];
            awaited_frames.push_back(r);
            parse_state = FS_HUNT;
            bytes_in = '0;
            sum_acc = '0;
        end
    endtask

    task automatic check_frame();
        frame_report_t want;
        if (awaited_frames.size() == 0) begin
            note_error($sformatf("unexpected frame: status %0d first %h ninth %h",
                m_frame_status, m_payload_first_eight, m_payload_ninth));
        end else begin
            want = awaited_frames.pop_front();
            if (m_frame_status !== want.status)
                note_error($sformatf("frame_status expected %0d got %0d",
                    want.status, m_frame_status));
            if (m_payload_first_eight !== want.first_eight)
                note_error($sformatf("payload_first_eight expected %h got %h",
                    want.first_eight, m_payload_first_eight));
            if (m_payload_ninth !== want.ninth)
                note_error($sformatf("payload_ninth expected %h got %h",
                    want.ninth, m_payload_ninth));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            header_value = HEADER_RESET;
            tail_value = TAIL_RESET;
            parse_state = FS_HUNT;
            bytes_in = '0;
            sum_acc = '0;
            sum_rx = '0;
            foreach (body[i])
                body[i] = '0;
            awaited_frames.delete();
        end else begin
            // compare before predicting so a fresh frame is never matched in its own cycle
            if (m_valid && m_ready)
                check_frame();
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_HEADER)
                    header_value = cfg_data;
                else if (cfg_index == REG_TAIL)
                    tail_value = cfg_data;
            end
            if (s_valid && s_ready)
                take_rx_byte(s_rx_byte);
        end
        frames_pending <= awaited_frames.size();
    end

endmodule

/* bench/fixed_frame_checksum_parser_test.sv */
// Testbench top for the fixed-frame checksum parser: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module fixed_frame_checksum_parser_test;
    import ffcp_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 2000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_rx_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_frame_status;
    logic [FIRST_W-1:0]    m_payload_first_eight;
    logic [BYTE_W-1:0]     m_payload_ninth;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [BYTE_W-1:0]     cfg_data;

    int                    mismatches;
    int                    frames_pending;
    int                    quiet_cycles;
    logic                  no_gaps;
    logic [BYTE_W-1:0]     cur_header;
    logic [BYTE_W-1:0]     cur_tail;
    logic [BYTE_W-1:0]     frame_body [PAYLOAD_LEN];

    fixed_frame_checksum_parser uut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_rx_byte             (s_rx_byte),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_frame_status        (m_frame_status),
        .m_payload_first_eight (m_payload_first_eight),
        .m_payload_ninth       (m_payload_ninth),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    frame_result_checker checker_i (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_rx_byte             (s_rx_byte),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_frame_status        (m_frame_status),
        .m_payload_first_eight (m_payload_first_eight),
        .m_payload_ninth       (m_payload_ninth),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .mismatches            (mismatches),
        .frames_pending        (frames_pending)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // count cycles in which no transaction completes on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        quiet_cycles = 0;
        wait (quiet_cycles >= STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // result side back-pressure in random bursts
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!no_gaps && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!no_gaps && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] sum_skew,
                              input logic [BYTE_W-1:0] tail_byte);
        logic [BYTE_W-1:0] sum;
        sum = '0;
        foreach (frame_body[i])
            sum = sum + frame_body[i];
        send_byte(cur_header);
        foreach (frame_body[i])
            send_byte(frame_body[i]);
        send_byte(sum + sum_skew);
        send_byte(tail_byte);
    endtask

    task automatic send_noise(input int count);
        logic [BYTE_W-1:0] b;
        repeat (count) begin
            do b = 8'($urandom_range(0, 255)); while (b == cur_header);
            send_byte(b);
        end
    endtask

    // hold the input until every predicted frame has been taken
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (frames_pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [BYTE_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic reconfigure(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] t,
                               input logic [CFG_ADDR_W-1:0] stray_idx);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_HEADER, h);
        write_reg(REG_TAIL, t);
        // unmapped index, must be ignored
        write_reg(stray_idx, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        cur_header = h;
        cur_tail = t;
    endtask

    task automatic random_frames(input int count);
        int mode;
        int pick;
        logic [BYTE_W-1:0] skew;
        logic [BYTE_W-1:0] tail_byte;
        repeat (count) begin
            if ($urandom_range(0, 4) == 0)
                send_noise($urandom_range(1, 4));
            foreach (frame_body[i]) begin
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    frame_body[i] = cur_header;
                else if (pick == 1)
                    frame_body[i] = 8'h00;
                else if (pick == 2)
                    frame_body[i] = 8'hFF;
                else
                    frame_body[i] = 8'($urandom_range(0, 255));
            end
            mode = $urandom_range(0, 15);
            skew = (mode == 1 || mode == 2) ? 8'($urandom_range(1, 255)) : 8'h00;
            tail_byte = (mode == 0 || mode == 2) ? cur_tail ^ 8'($urandom_range(1, 255))
                                                 : cur_tail;
            send_frame(skew, tail_byte);
            if ($urandom_range(0, 19) == 0)
                drain();
        end
    endtask

    initial begin
        s_valid <= 1'b0;
        s_rx_byte <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        aresetn <= 1'b0;
        no_gaps = 1'b0;
        cur_header = HEADER_RESET;
        cur_tail = TAIL_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // noise while hunting, then a good frame with header and tail values in the payload
        send_byte(8'h00);
        send_byte(8'hFF);
        frame_body = '{8'hA5, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hA5, 8'h5A};
        send_frame(8'h00, cur_tail);
        // checksum off by one, wrapped sum
        frame_body = '{default: 8'hFF};
        send_frame(8'h01, cur_tail);
        // tail and checksum both wrong: tail wins
        frame_body = '{default: 8'h00};
        send_frame(8'h80, ~cur_tail);
        drain();

        random_frames(8);
        reconfigure(8'h00, 8'hFF, 8'hFE);
        random_frames(8);
        reconfigure(8'hFF, 8'h00, 8'h02);
        random_frames(8);
        reconfigure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(2, 255)));
        random_frames(8);
        reconfigure(HEADER_RESET, TAIL_RESET, 8'h80);
        no_gaps = 1'b1;
        random_frames(8);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/ffcp_pkg.sv
rtl/ffcp_front.sv
rtl/ffcp_queue.sv
rtl/ffcp_back.sv
rtl/fixed_frame_checksum_parser.sv
rtl/ffcp_checker.sv
bench/frame_result_checker.sv
bench/fixed_frame_checksum_parser_test.sv
